@@ design/gab_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gab_pkg
// Shared types and constants of the graph adjacency builder: request and
// status codes, and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package gab_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_DEGREE_DEF   = 32;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // slot that the neighbour store is read at: relative to the slot counter, or slot zero
    typedef enum logic [1:0] {
        RD_KM1  = 2'd0,
        RD_KM2  = 2'd1,
        RD_ZERO = 2'd2,
        RD_KP1  = 2'd3
    } nb_rd_sel_t;

    typedef enum logic {
        WR_SHIFT = 1'b0,
        WR_VAL   = 1'b1
    } nb_wr_sel_t;

    typedef enum logic [1:0] {
        OUT_ACK  = 2'd0,
        OUT_HEAD = 2'd1,
        OUT_NB   = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic       capture;
        logic       tbl_rd_u;
        logic       tbl_rd_v;
        logic       u_capture;
        logic       tbl_wr_u;
        logic       tbl_wr_v;
        logic       vlimit_upd;
        logic       ins_load_first;
        logic       ins_load_second;
        logic       k_clear;
        logic       k_inc;
        logic       k_dec;
        logic       nb_rd;
        nb_rd_sel_t nb_rd_sel;
        logic       nb_wr;
        nb_wr_sel_t nb_wr_sel;
        logic       status_we;
        status_t    status_code;
        logic       out_load;
        out_kind_t  out_kind;
    } gab_cmd_t;

    typedef struct packed {
        logic range_err;
        logic full_err;
        logic self_loop;
        logic req_read;
        logic k_zero;
        logic k_one;
        logic greater;
        logic ro_empty;
        logic ro_last;
        logic out_free;
    } gab_sts_t;

endpackage

@@ design/graph_adjacency_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_adjacency_builder
// Undirected multigraph store: symmetric adjacency rows plus a sorted
// neighbour list per vertex, filled edge by edge and read back per vertex.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: req_type 0 adds
//   edge (first_vertex, second_vertex), req_type 1 reads out first_vertex.
//   Output channel (out_valid / out_stall) returns one acknowledge per add or
//   rejected readout, and a header plus one item per list entry per readout
//   in range, last on the final. One request is worked on at a time;
//   in_stall is high while it runs. An accepted add ends in one sorted
//   insertion per endpoint; the insertion walks the neighbour store with one
//   read and one write port. Readout: a header, then one neighbour per cycle
//   while out_stall is low. Rejected requests (range or full list) skip the
//   table update and go straight to the acknowledge.
//   A result waits in the output register while out_stall is high; the
//   controller holds its next item until that register is free, and a new
//   request may be taken while the final result of the last one still waits.
//   Reset clears the adjacency rows, list lengths and vertex count at once
//   (per-row valid bits); neighbour store contents need no clearing.
// ----------------------------------------------------------------------------
module graph_adjacency_builder #(
    parameter int MAX_VERTICES = gab_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = gab_pkg::MAX_DEGREE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [6:0]  first_vertex,
    input  logic [6:0]  second_vertex,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        is_neighbour,
    output logic [63:0] row_bits,
    output logic [6:0]  vertex_count,
    output logic [5:0]  neighbour_count,
    output logic [5:0]  neighbour,
    output logic        last
);

    gab_pkg::gab_cmd_t cmd;
    gab_pkg::gab_sts_t sts;

    gab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gab_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_type        (req_type),
        .first_vertex    (first_vertex),
        .second_vertex   (second_vertex),
        .cmd             (cmd),
        .sts             (sts),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .status          (status),
        .is_neighbour    (is_neighbour),
        .row_bits        (row_bits),
        .vertex_count    (vertex_count),
        .neighbour_count (neighbour_count),
        .neighbour       (neighbour),
        .last            (last)
    );

endmodule

@@ design/gab_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gab_datapath
// Request registers, vertex table (row bits and list length per vertex),
// neighbour store, vertex limit and the output register.
// ----------------------------------------------------------------------------
module gab_datapath #(
    parameter int MAX_VERTICES = gab_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = gab_pkg::MAX_DEGREE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_type,
    input  logic [6:0]       first_vertex,
    input  logic [6:0]       second_vertex,
    input  gab_pkg::gab_cmd_t cmd,
    output gab_pkg::gab_sts_t sts,
    input  logic             out_stall,
    output logic             out_valid,
    output logic [1:0]       status,
    output logic             is_neighbour,
    output logic [63:0]      row_bits,
    output logic [6:0]       vertex_count,
    output logic [5:0]       neighbour_count,
    output logic [5:0]       neighbour,
    output logic             last
);

    localparam int VW       = $clog2(MAX_VERTICES);
    localparam int SW       = $clog2(MAX_DEGREE);
    localparam int CW       = $clog2(MAX_DEGREE + 1);
    localparam int LW       = $clog2(MAX_VERTICES + 1);
    localparam int TW       = CW + MAX_VERTICES;
    localparam int NB_DEPTH = 2 ** (VW + SW);
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    // request registers
    logic            req_reg;
    logic [6:0]      u_raw_reg;
    logic [6:0]      v_raw_reg;
    logic [VW-1:0]   u_idx;
    logic [VW-1:0]   v_idx;

    // vertex table
    logic [TW-1:0]           tbl_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] tbl_valid_reg;
    logic [TW-1:0]           tbl_rdata_reg;
    logic [TW-1:0]           u_entry_reg;
    logic [VW-1:0]           tbl_raddr;
    logic [VW-1:0]           tbl_waddr;
    logic [TW-1:0]           tbl_wdata;
    logic [CW-1:0]           len_u;
    logic [CW-1:0]           len_v;
    logic [MAX_VERTICES-1:0] row_u;
    logic [MAX_VERTICES-1:0] row_v;
    logic [CW-1:0]           inc_u;

    // neighbour store
    logic [VW-1:0]  nb_mem [NB_DEPTH];
    logic [VW-1:0]  nb_rdata_reg;
    logic [VW-1:0]  ins_vtx_reg;
    logic [VW-1:0]  ins_val_reg;
    logic [CW-1:0]  k_reg;
    logic [CW-1:0]  rd_slot;
    logic [VW-1:0]  nb_wdata;

    logic [LW-1:0]  vlimit_reg;
    logic [VW-1:0]  max_idx;
    logic [LW-1:0]  top;

    gab_pkg::status_t status_reg;

    // output register
    logic           out_valid_reg;
    logic [1:0]     status_out_reg;
    logic           is_nb_out_reg;
    logic [63:0]    row_out_reg;
    logic [6:0]     vcount_out_reg;
    logic [5:0]     ncount_out_reg;
    logic [5:0]     nb_out_reg;
    logic           last_out_reg;

    assign u_idx = u_raw_reg[VW-1:0];
    assign v_idx = v_raw_reg[VW-1:0];
    assign len_u = u_entry_reg[TW-1 -: CW];
    assign row_u = u_entry_reg[MAX_VERTICES-1:0];
    assign len_v = tbl_rdata_reg[TW-1 -: CW];
    assign row_v = tbl_rdata_reg[MAX_VERTICES-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            u_raw_reg <= first_vertex;
            v_raw_reg <= second_vertex;
        end
        if (cmd.u_capture)
        begin
            u_entry_reg <= tbl_rdata_reg;
        end
        if (cmd.status_we)
        begin
            status_reg <= cmd.status_code;
        end
    end

    // ---- vertex table ----
    assign tbl_raddr = cmd.tbl_rd_v ? v_idx : u_idx;
    assign inc_u     = (u_idx == v_idx) ? CW'(2) : CW'(1);

    always_comb
    begin
        if (cmd.tbl_wr_v)
        begin
            tbl_waddr = v_idx;
            tbl_wdata = {len_v + CW'(1), row_v | (ROW_ONE << u_idx)};
        end
        else
        begin
            tbl_waddr = u_idx;
            tbl_wdata = {len_u + inc_u, row_u | (ROW_ONE << v_idx)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr_u || cmd.tbl_wr_v)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (cmd.tbl_rd_u || cmd.tbl_rd_v)
        begin
            // an entry never written reads as cleared
            tbl_rdata_reg <= tbl_valid_reg[tbl_raddr] ? tbl_mem[tbl_raddr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
        end
        else if (cmd.tbl_wr_u || cmd.tbl_wr_v)
        begin
            tbl_valid_reg[tbl_waddr] <= 1'b1;
        end
    end

    // ---- vertex limit ----
    assign max_idx = (u_idx > v_idx) ? u_idx : v_idx;
    assign top     = LW'(max_idx) + LW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlimit_reg <= '0;
        end
        else if (cmd.vlimit_upd && (top > vlimit_reg))
        begin
            vlimit_reg <= top;
        end
    end

    // ---- insertion and readout cursor ----
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ins_vtx_reg <= first_vertex[VW-1:0];
        end
        else if (cmd.ins_load_first)
        begin
            ins_vtx_reg <= u_idx;
            ins_val_reg <= v_idx;
        end
        else if (cmd.ins_load_second)
        begin
            ins_vtx_reg <= v_idx;
            ins_val_reg <= u_idx;
        end

        if (cmd.ins_load_first)
        begin
            k_reg <= len_u;
        end
        else if (cmd.ins_load_second)
        begin
            // a self-loop inserts into the list that just grew by one
            k_reg <= (u_idx == v_idx) ? (len_u + CW'(1)) : len_v;
        end
        else if (cmd.k_clear)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + CW'(1);
        end
        else if (cmd.k_dec)
        begin
            k_reg <= k_reg - CW'(1);
        end
    end

    // ---- neighbour store ----
    always_comb
    begin
        case (cmd.nb_rd_sel)
            gab_pkg::RD_KM1:  rd_slot = k_reg - CW'(1);
            gab_pkg::RD_KM2:  rd_slot = k_reg - CW'(2);
            gab_pkg::RD_ZERO: rd_slot = '0;
            gab_pkg::RD_KP1:  rd_slot = k_reg + CW'(1);
            default:          rd_slot = '0;
        endcase
    end

    assign nb_wdata = (cmd.nb_wr_sel == gab_pkg::WR_VAL) ? ins_val_reg : nb_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.nb_wr)
        begin
            nb_mem[{ins_vtx_reg, k_reg[SW-1:0]}] <= nb_wdata;
        end
        if (cmd.nb_rd)
        begin
            nb_rdata_reg <= nb_mem[{ins_vtx_reg, rd_slot[SW-1:0]}];
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                gab_pkg::OUT_HEAD:
                begin
                    status_out_reg <= gab_pkg::ST_OK;
                    is_nb_out_reg  <= 1'b0;
                    row_out_reg    <= 64'(row_v);
                    vcount_out_reg <= 7'(vlimit_reg);
                    ncount_out_reg <= 6'(len_v);
                    nb_out_reg     <= '0;
                    last_out_reg   <= sts.ro_empty;
                end
                gab_pkg::OUT_NB:
                begin
                    status_out_reg <= gab_pkg::ST_OK;
                    is_nb_out_reg  <= 1'b1;
                    row_out_reg    <= '0;
                    vcount_out_reg <= '0;
                    ncount_out_reg <= '0;
                    nb_out_reg     <= 6'(nb_rdata_reg);
                    last_out_reg   <= sts.ro_last;
                end
                default:
                begin
                    status_out_reg <= status_reg;
                    is_nb_out_reg  <= 1'b0;
                    row_out_reg    <= '0;
                    vcount_out_reg <= 7'(vlimit_reg);
                    ncount_out_reg <= '0;
                    nb_out_reg     <= '0;
                    last_out_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_out_reg;
    assign is_neighbour    = is_nb_out_reg;
    assign row_bits        = row_out_reg;
    assign vertex_count    = vcount_out_reg;
    assign neighbour_count = ncount_out_reg;
    assign neighbour       = nb_out_reg;
    assign last            = last_out_reg;

    // ---- status to controller ----
    // readout takes its row and length from the table read data
    always_comb
    begin
        sts.range_err = (u_raw_reg >= 7'(MAX_VERTICES))
                      || ((req_reg == gab_pkg::REQ_ADD) && (v_raw_reg >= 7'(MAX_VERTICES)));
        sts.self_loop = (u_idx == v_idx);
        if (u_idx == v_idx)
        begin
            sts.full_err = ((CW+1)'(len_u) + (CW+1)'(2)) > (CW+1)'(MAX_DEGREE);
        end
        else
        begin
            sts.full_err = (len_u >= CW'(MAX_DEGREE)) || (len_v >= CW'(MAX_DEGREE));
        end
        sts.req_read = (req_reg == gab_pkg::REQ_READ);
        sts.k_zero   = (k_reg == '0);
        sts.k_one    = (k_reg == CW'(1));
        sts.greater  = (nb_rdata_reg > ins_val_reg);
        sts.ro_empty = (len_v == '0);
        sts.ro_last  = ((k_reg + CW'(1)) == len_v);
        sts.out_free = !out_valid_reg || !out_stall;
    end

endmodule

@@ design/gab_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gab_ctrl
// Sequencer of the graph adjacency builder: decodes a request, runs the
// table update and the two sorted insertions, and streams a readout.
// ----------------------------------------------------------------------------
module gab_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gab_pkg::gab_sts_t sts,
    output gab_pkg::gab_cmd_t cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DECODE    = 12'b0000_0000_0010,
        S_RD_V      = 12'b0000_0000_0100,
        S_CHECK     = 12'b0000_0000_1000,
        S_WR_U      = 12'b0000_0001_0000,
        S_WR_V      = 12'b0000_0010_0000,
        S_INS_START = 12'b0000_0100_0000,
        S_INS_SHIFT = 12'b0000_1000_0000,
        S_INS_PLACE = 12'b0001_0000_0000,
        S_ACK       = 12'b0010_0000_0000,
        S_RO_HEAD   = 12'b0100_0000_0000,
        S_RO_EMIT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second_reg;
    logic   second_next;
    state_t ins_done_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign ins_done_state = second_reg ? S_ACK : S_INS_START;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        second_next = second_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.status_we = 1'b1;
                if (sts.range_err)
                begin
                    cmd.status_code = gab_pkg::ST_RANGE;
                    state_next      = S_ACK;
                end
                else
                begin
                    cmd.status_code = gab_pkg::ST_OK;
                    cmd.tbl_rd_u    = 1'b1;
                    state_next      = sts.req_read ? S_RO_HEAD : S_RD_V;
                end
            end
            S_RD_V:
            begin
                cmd.u_capture = 1'b1;
                cmd.tbl_rd_v  = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.full_err)
                begin
                    cmd.status_we   = 1'b1;
                    cmd.status_code = gab_pkg::ST_FULL;
                    state_next      = S_ACK;
                end
                else
                begin
                    state_next = S_WR_U;
                end
            end
            S_WR_U:
            begin
                cmd.tbl_wr_u       = 1'b1;
                cmd.vlimit_upd     = 1'b1;
                cmd.ins_load_first = 1'b1;
                second_next        = 1'b0;
                state_next         = sts.self_loop ? S_INS_START : S_WR_V;
            end
            S_WR_V:
            begin
                cmd.tbl_wr_v = 1'b1;
                state_next   = S_INS_START;
            end
            S_INS_START:
            begin
                if (sts.k_zero)
                begin
                    cmd.nb_wr           = 1'b1;
                    cmd.nb_wr_sel       = gab_pkg::WR_VAL;
                    cmd.ins_load_second = !second_reg;
                    second_next         = 1'b1;
                    state_next          = ins_done_state;
                end
                else
                begin
                    cmd.nb_rd     = 1'b1;
                    cmd.nb_rd_sel = gab_pkg::RD_KM1;
                    state_next    = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT:
            begin
                cmd.nb_wr = 1'b1;
                if (sts.greater)
                begin
                    // move the entry up one slot, fetch the one below ahead
                    cmd.nb_wr_sel = gab_pkg::WR_SHIFT;
                    cmd.k_dec     = 1'b1;
                    if (sts.k_one)
                    begin
                        state_next = S_INS_PLACE;
                    end
                    else
                    begin
                        cmd.nb_rd     = 1'b1;
                        cmd.nb_rd_sel = gab_pkg::RD_KM2;
                    end
                end
                else
                begin
                    cmd.nb_wr_sel       = gab_pkg::WR_VAL;
                    cmd.ins_load_second = !second_reg;
                    second_next         = 1'b1;
                    state_next          = ins_done_state;
                end
            end
            S_INS_PLACE:
            begin
                cmd.nb_wr           = 1'b1;
                cmd.nb_wr_sel       = gab_pkg::WR_VAL;
                cmd.ins_load_second = !second_reg;
                second_next         = 1'b1;
                state_next          = ins_done_state;
            end
            S_ACK:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = gab_pkg::OUT_ACK;
                    state_next   = S_IDLE;
                end
            end
            S_RO_HEAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = gab_pkg::OUT_HEAD;
                    cmd.k_clear  = 1'b1;
                    if (sts.ro_empty)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.nb_rd     = 1'b1;
                        cmd.nb_rd_sel = gab_pkg::RD_ZERO;
                        state_next    = S_RO_EMIT;
                    end
                end
            end
            S_RO_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = gab_pkg::OUT_NB;
                    if (sts.ro_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.k_inc     = 1'b1;
                        cmd.nb_rd     = 1'b1;
                        cmd.nb_rd_sel = gab_pkg::RD_KP1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/gab_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gab_checker
// Port-level checks of the graph adjacency builder, bound to the top level.
// ----------------------------------------------------------------------------
module gab_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic        is_neighbour,
    input logic [63:0] row_bits,
    input logic [6:0]  vertex_count,
    input logic [5:0]  neighbour_count,
    input logic [5:0]  neighbour,
    input logic        last
);

    // one request at a time: a taken request blocks the next one
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one in progress");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({status, is_neighbour, row_bits, vertex_count,
                        neighbour_count, neighbour, last}))
        else $error("stalled result changed");

    a_neighbour_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_neighbour |-> status == gab_pkg::ST_OK && row_bits == 64'd0
            && vertex_count == 7'd0 && neighbour_count == 6'd0)
        else $error("neighbour item carries header fields");

    // a header announcing entries cannot be the final item
    a_header_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_neighbour && neighbour_count != 6'd0
            |-> !last && status == gab_pkg::ST_OK)
        else $error("non-empty header marked last");

endmodule

bind graph_adjacency_builder gab_checker u_gab_checker (.*);

@@ tb/graph_adjacency_builder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_adjacency_builder_tb
// Sends edge-add and vertex-readout requests to the adjacency builder and
// keeps a shadow copy of the graph that predicts every reply. Each reply is
// checked field by field, with random gaps and stalls on both channels and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module graph_adjacency_builder_tb;

    localparam int NUM_VERTICES   = gab_pkg::MAX_VERTICES_DEF;
    localparam int DEGREE_CAP     = gab_pkg::MAX_DEGREE_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        gab_pkg::status_t status;
        logic             is_nb;
        logic [63:0]      row;
        logic [6:0]       vcount;
        logic [5:0]       ncount;
        logic [5:0]       nb;
        logic             last;
    } graph_reply_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [6:0]  first_vertex;
    logic [6:0]  second_vertex;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        is_neighbour;
    logic [63:0] row_bits;
    logic [6:0]  vertex_count;
    logic [5:0]  neighbour_count;
    logic [5:0]  neighbour;
    logic        last;

    // shadow copy of the graph
    logic [63:0]  shadow_rows [NUM_VERTICES];
    logic [5:0]   shadow_lists [NUM_VERTICES][DEGREE_CAP];
    int           shadow_len [NUM_VERTICES];
    logic [6:0]   shadow_limit;
    graph_reply_t pending_replies [$];

    int mismatch_count;
    int replies_checked;
    int adds_sent;
    int reads_sent;
    int range_drops;
    int full_drops;
    bit idle_enable;
    int hold_start_count;
    int hold_seen;
    int rx_hold_left;
    int rx_gap_left;
    int idle_cycles;

    graph_adjacency_builder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .first_vertex    (first_vertex),
        .second_vertex   (second_vertex),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .is_neighbour    (is_neighbour),
        .row_bits        (row_bits),
        .vertex_count    (vertex_count),
        .neighbour_count (neighbour_count),
        .neighbour       (neighbour),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic graph_reply_t blank_reply();
        graph_reply_t r;
        r.status = gab_pkg::ST_OK;
        r.is_nb  = 1'b0;
        r.row    = '0;
        r.vcount = '0;
        r.ncount = '0;
        r.nb     = '0;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic [6:0] pick_vertex();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 7'($urandom_range(NUM_VERTICES, 127));
        if (r < 40)
            return 7'($urandom_range(0, 5));
        return 7'($urandom_range(0, NUM_VERTICES - 1));
    endfunction

    task automatic insert_sorted(int vtx, logic [5:0] val);
        int pos;
        pos = shadow_len[vtx];
        while (pos > 0 && shadow_lists[vtx][pos - 1] > val)
            pos--;
        for (int k = shadow_len[vtx]; k > pos; k--)
            shadow_lists[vtx][k] = shadow_lists[vtx][k - 1];
        shadow_lists[vtx][pos] = val;
        shadow_len[vtx]++;
    endtask

    // update the shadow graph and queue the replies one request causes
    task automatic apply_request(logic rt, logic [6:0] u, logic [6:0] v);
        graph_reply_t     r;
        gab_pkg::status_t st;
        int               len;
        int               top;
        r = blank_reply();
        if (rt == gab_pkg::REQ_ADD)
        begin
            adds_sent++;
            st = gab_pkg::ST_OK;
            if (u >= NUM_VERTICES || v >= NUM_VERTICES)
                st = gab_pkg::ST_RANGE;
            else if (u == v)
            begin
                // a self-loop takes two slots of the same list
                if (shadow_len[u] + 2 > DEGREE_CAP)
                    st = gab_pkg::ST_FULL;
            end
            else if (shadow_len[u] >= DEGREE_CAP || shadow_len[v] >= DEGREE_CAP)
                st = gab_pkg::ST_FULL;
            if (st == gab_pkg::ST_OK)
            begin
                shadow_rows[u][v] = 1'b1;
                shadow_rows[v][u] = 1'b1;
                insert_sorted(u, v[5:0]);
                insert_sorted(v, u[5:0]);
                top = ((u > v) ? u : v) + 1;
                if (top > shadow_limit)
                    shadow_limit = 7'(top);
            end
            else if (st == gab_pkg::ST_RANGE)
                range_drops++;
            else
                full_drops++;
            r.status = st;
            r.vcount = shadow_limit;
            r.last   = 1'b1;
            pending_replies.push_back(r);
        end
        else
        begin
            reads_sent++;
            r.vcount = shadow_limit;
            if (u >= NUM_VERTICES)
            begin
                r.status = gab_pkg::ST_RANGE;
                r.last   = 1'b1;
                pending_replies.push_back(r);
            end
            else
            begin
                len      = shadow_len[u];
                r.row    = shadow_rows[u];
                r.ncount = 6'(len);
                r.last   = (len == 0);
                pending_replies.push_back(r);
                for (int k = 0; k < len; k++)
                begin
                    r       = blank_reply();
                    r.is_nb = 1'b1;
                    r.nb    = shadow_lists[u][k];
                    r.last  = (k == len - 1);
                    pending_replies.push_back(r);
                end
            end
        end
    endtask

    task automatic send_request(logic rt, logic [6:0] u, logic [6:0] v);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            // payload is noise while valid is low
            in_valid      <= 1'b0;
            req_type      <= 1'($urandom_range(0, 1));
            first_vertex  <= 7'($urandom_range(0, 127));
            second_vertex <= 7'($urandom_range(0, 127));
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= rt;
        first_vertex  <= u;
        second_vertex <= v;
        do @(posedge clk); while (in_stall);
        apply_request(rt, u, v);
    endtask

    task automatic check_reply();
        graph_reply_t want;
        replies_checked++;
        if (pending_replies.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected reply: st=%0d nb_item=%0b row=%h vc=%0d nc=%0d n=%0d last=%0b",
                         status, is_neighbour, row_bits, vertex_count, neighbour_count,
                         neighbour, last);
        end
        else
        begin
            want = pending_replies.pop_front();
            if (status !== want.status || is_neighbour !== want.is_nb ||
                row_bits !== want.row || vertex_count !== want.vcount ||
                neighbour_count !== want.ncount || neighbour !== want.nb ||
                last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("reply %0d mismatch at %0t", replies_checked, $realtime);
                    $display("  expected st=%0d nb_item=%0b row=%h vc=%0d nc=%0d n=%0d last=%0b",
                             want.status, want.is_nb, want.row, want.vcount, want.ncount,
                             want.nb, want.last);
                    $display("  actual   st=%0d nb_item=%0b row=%h vc=%0d nc=%0d n=%0d last=%0b",
                             status, is_neighbour, row_bits, vertex_count, neighbour_count,
                             neighbour, last);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_reply();
    end

    // receiver: random stall bursts, plus a long hold-off when asked
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_start_count)
            begin
                hold_seen    = hold_start_count;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left--;
                out_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                rx_gap_left = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: cycles in a row with no request or reply moving
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no progress for %0d cycles, %0d replies outstanding",
                 WATCHDOG_LIMIT, pending_replies.size());
        $display("Verification failed");
        $finish;
    end

    task automatic test_empty_graph();
        send_request(gab_pkg::REQ_READ, 7'd0, 7'd0);
        send_request(gab_pkg::REQ_READ, 7'd63, 7'd127);
        send_request(gab_pkg::REQ_READ, 7'd64, 7'd0);
        send_request(gab_pkg::REQ_READ, 7'd127, 7'd127);
        send_request(gab_pkg::REQ_ADD, 7'd64, 7'd0);
        send_request(gab_pkg::REQ_ADD, 7'd0, 7'd127);
    endtask

    task automatic test_edge_order();
        send_request(gab_pkg::REQ_ADD, 7'd0, 7'd63);
        send_request(gab_pkg::REQ_ADD, 7'd63, 7'd0);
        send_request(gab_pkg::REQ_ADD, 7'd5, 7'd5);
        send_request(gab_pkg::REQ_ADD, 7'd10, 7'd7);
        send_request(gab_pkg::REQ_ADD, 7'd10, 7'd1);
        send_request(gab_pkg::REQ_ADD, 7'd10, 7'd3);
        send_request(gab_pkg::REQ_ADD, 7'd10, 7'd7);
        send_request(gab_pkg::REQ_ADD, 7'd1, 7'd10);
        send_request(gab_pkg::REQ_READ, 7'd10, 7'd127);
        send_request(gab_pkg::REQ_READ, 7'd5, 7'd0);
        send_request(gab_pkg::REQ_READ, 7'd0, 7'd85);
        send_request(gab_pkg::REQ_READ, 7'd63, 7'd42);
        send_request(gab_pkg::REQ_READ, 7'd1, 7'd0);
        send_request(gab_pkg::REQ_READ, 7'd2, 7'd0);
    endtask

    task automatic test_list_full();
        repeat (14) send_request(gab_pkg::REQ_ADD, 7'd20, 7'd20);
        send_request(gab_pkg::REQ_ADD, 7'd20, 7'd40);
        send_request(gab_pkg::REQ_ADD, 7'd2, 7'd20);
        send_request(gab_pkg::REQ_ADD, 7'd20, 7'd63);
        // one slot left, a self-loop needs two
        send_request(gab_pkg::REQ_ADD, 7'd20, 7'd20);
        send_request(gab_pkg::REQ_ADD, 7'd20, 7'd9);
        send_request(gab_pkg::REQ_ADD, 7'd20, 7'd11);
        send_request(gab_pkg::REQ_ADD, 7'd11, 7'd20);
        // range fault wins over a full list
        send_request(gab_pkg::REQ_ADD, 7'd20, 7'd100);
        send_request(gab_pkg::REQ_ADD, 7'd100, 7'd20);
        send_request(gab_pkg::REQ_READ, 7'd20, 7'd0);
        send_request(gab_pkg::REQ_READ, 7'd9, 7'd0);
    endtask

    task automatic test_random_traffic(int count);
        logic       rt;
        logic [6:0] u;
        logic [6:0] v;
        repeat (count)
        begin
            u = pick_vertex();
            if ($urandom_range(0, 3) == 0)
            begin
                rt = gab_pkg::REQ_READ;
                v  = 7'($urandom_range(0, 127));
            end
            else
            begin
                rt = gab_pkg::REQ_ADD;
                v  = ($urandom_range(0, 11) == 0) ? u : pick_vertex();
            end
            send_request(rt, u, v);
        end
    endtask

    task automatic test_backpressure();
        idle_enable = 1'b0;
        hold_start_count++;
        send_request(gab_pkg::REQ_READ, 7'd20, 7'd0);
        send_request(gab_pkg::REQ_ADD, 7'd3, 7'd4);
        send_request(gab_pkg::REQ_READ, 7'd20, 7'd1);
        send_request(gab_pkg::REQ_ADD, 7'd12, 7'd3);
        send_request(gab_pkg::REQ_READ, 7'd3, 7'd0);
        send_request(gab_pkg::REQ_READ, 7'd10, 7'd0);
        send_request(gab_pkg::REQ_ADD, 7'd90, 7'd3);
        send_request(gab_pkg::REQ_READ, 7'd0, 7'd0);
        idle_enable = 1'b1;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= gab_pkg::REQ_ADD;
        first_vertex  <= '0;
        second_vertex <= '0;
        idle_enable      = 1'b1;
        hold_start_count = 0;
        hold_seen        = 0;
        rx_hold_left     = 0;
        rx_gap_left      = 0;
        mismatch_count   = 0;
        replies_checked  = 0;
        adds_sent        = 0;
        reads_sent       = 0;
        range_drops      = 0;
        full_drops       = 0;
        shadow_limit     = '0;
        for (int i = 0; i < NUM_VERTICES; i++)
        begin
            shadow_rows[i] = '0;
            shadow_len[i]  = 0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_graph();
        test_edge_order();
        test_list_full();
        test_random_traffic(90);
        test_backpressure();
        // closing stretch runs without gaps or stalls
        idle_enable = 1'b0;
        test_random_traffic(60);

        in_valid <= 1'b0;
        while (pending_replies.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d edge adds and %0d readouts, %0d replies checked",
                 adds_sent, reads_sent, replies_checked);
        $display("adds dropped: %0d out of range, %0d on a full list; %0d mismatches",
                 range_drops, full_drops, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
